[design/spq_pkg.sv]
package spq_pkg;

   localparam int DEPTH = 32;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int KEY_W = 32;
   localparam int OCC_W = 6;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_OVERFLOW  = 2'd1,
      ST_UNDERFLOW = 2'd2
   } status_type;

   typedef enum logic {
      KIND_ENQ = 1'b0,
      KIND_DEQ = 1'b1
   } kind_type;

   typedef struct packed {
      logic               enq;
      logic               deq;
      logic signed [KEY_W-1:0] key;
   } cell_ctrl_type;

   typedef struct packed {
      status_type              status;
      logic signed [KEY_W-1:0] key_out;
      logic [OCC_W-1:0]        occupancy;
   } rsp_type;

endpackage

[design/spq_cell.sv]
module spq_cell
   import spq_pkg::*;
(
   input  logic                    clock,
   input  cell_ctrl_type           ctrl,
   input  logic                    occ,
   input  logic signed [KEY_W-1:0] left_key,
   input  logic                    left_gt,
   input  logic signed [KEY_W-1:0] right_key,
   output logic signed [KEY_W-1:0] key,
   output logic                    gt
);

   logic signed [KEY_W-1:0] key_ff;
   logic signed [KEY_W-1:0] key_in;

   assign gt  = occ && (key_ff > ctrl.key);
   assign key = key_ff;

   always_comb begin
      key_in = key_ff;
      if (ctrl.enq) begin
         if (left_gt) begin
            key_in = left_key;
         end else if (gt || !occ) begin
            key_in = ctrl.key;
         end
      end else if (ctrl.deq) begin
         key_in = right_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

[design/spq_out.sv]
module spq_out
   import spq_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_stall,
   input  rsp_type in_data,
   output logic    out_valid,
   input  logic    out_stall,
   output rsp_type out_data
);

   logic    main_valid_ff, main_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type main_ff, main_in;
   rsp_type skid_ff, skid_in;
   logic    take;

   assign take      = main_valid_ff && !out_stall;
   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!main_valid_ff || take) begin
            main_in       = in_data;
            main_valid_in = 1'b1;
         end else begin
            skid_in       = in_data;
            skid_valid_in = 1'b1;
         end
      end else if (take) begin
         main_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

`ifndef SYNTH
   a_skid_needs_main: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> main_valid_ff)
      else $error("skid holds a transaction while output is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && !out_stall |=> !skid_valid_ff)
      else $error("skid did not drain on take");

   a_skid_fills: assert property (@(posedge clock) disable iff (reset)
      in_valid && !in_stall && main_valid_ff && out_stall |=> skid_valid_ff)
      else $error("transaction lost while output stalled");

   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && out_stall |=> $stable(skid_ff))
      else $error("skid data changed while held");
`endif

endmodule

[design/sorted_insert_priority_queue.sv]
// sorted_insert_priority_queue: ascending priority queue of signed 32-bit keys
// held in a row of cells, smallest key in cell 0.
// request channel (req_valid/req_stall): req_kind selects enqueue of
// req_key_in or dequeue of the smallest key. equal keys leave in arrival order.
// response channel (rsp_valid/rsp_stall): one transaction per request with
// rsp_status (ok, overflow on full enqueue, underflow on empty dequeue),
// rsp_key_out (removed key, else zero) and rsp_occupancy after the operation.
// every cell compares its key with the incoming key and shifts toward its
// neighbor in the same cycle. the response is registered in the response
// register, or in the skid stage while the receiver stalls.
// throughput: one request per cycle while responses are taken.
// a response register plus a skid stage absorb a stalled receiver; req_stall
// rises only once both hold a response, and falls in the cycle after one is taken.
// reset clears the count and output stages; cell contents need no clearing
// since only cells below the count are read.
module sorted_insert_priority_queue
   import spq_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_kind,
   input  logic signed [KEY_W-1:0] req_key_in,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [1:0]              rsp_status,
   output logic signed [KEY_W-1:0] rsp_key_out,
   output logic [OCC_W-1:0]        rsp_occupancy
);

   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    accept, full, empty;
   cell_ctrl_type           ctrl;
   rsp_type                 rsp_new, rsp_data;
   logic signed [KEY_W-1:0] keys [DEPTH];
   logic                    gts  [DEPTH];
   logic [CNT_W+OCC_W-1:0]  occ_wide;

   assign accept = req_valid && !req_stall;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign empty  = (count_ff == '0);

   always_comb begin
      ctrl.enq         = 1'b0;
      ctrl.deq         = 1'b0;
      ctrl.key         = req_key_in;
      count_in         = count_ff;
      rsp_new.status   = ST_OK;
      rsp_new.key_out  = '0;
      if (accept) begin
         case (kind_type'(req_kind))
            KIND_ENQ: begin
               if (full) begin
                  rsp_new.status = ST_OVERFLOW;
               end else begin
                  ctrl.enq = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            KIND_DEQ: begin
               if (empty) begin
                  rsp_new.status = ST_UNDERFLOW;
               end else begin
                  ctrl.deq        = 1'b1;
                  rsp_new.key_out = keys[0];
                  count_in        = count_ff - CNT_W'(1);
               end
            end
            default: begin
               rsp_new.status = ST_OK;
            end
         endcase
      end
      occ_wide          = {{OCC_W{1'b0}}, count_in};
      rsp_new.occupancy = occ_wide[OCC_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic signed [KEY_W-1:0] left_key, right_key;
         logic                    left_gt;
         if (g == 0) begin : g_first
            assign left_key = req_key_in;
            assign left_gt  = 1'b0;
         end else begin : g_mid
            assign left_key = keys[g-1];
            assign left_gt  = gts[g-1];
         end
         if (g == DEPTH - 1) begin : g_last
            assign right_key = keys[g];
         end else begin : g_body
            assign right_key = keys[g+1];
         end
         spq_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .occ       (count_ff > CNT_W'(g)),
            .left_key  (left_key),
            .left_gt   (left_gt),
            .right_key (right_key),
            .key       (keys[g]),
            .gt        (gts[g])
         );
      end
   endgenerate

   spq_out u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_stall  (req_stall),
      .in_data   (rsp_new),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (rsp_data)
   );

   assign rsp_status    = rsp_data.status;
   assign rsp_key_out   = rsp_data.key_out;
   assign rsp_occupancy = rsp_data.occupancy;

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("count beyond capacity");

   a_full_enq_keeps: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_ENQ && full |=> $stable(count_ff))
      else $error("overflow changed the count");

   a_deq_drops: assert property (@(posedge clock) disable iff (reset)
      accept && req_kind == KIND_DEQ && !empty |=> count_ff == $past(count_ff) - CNT_W'(1))
      else $error("dequeue did not drop the count");
`endif

endmodule
